/* rtl/round_robin_task_scheduler_macros.svh */
// Assertion macros used by the scheduler checker
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RRTS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define RRTS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

/* rtl/rrts_pkg.sv */
// Types, codes and constants of the round-robin task scheduler
package rrts_pkg;

	// table size, fixed field widths, frame size and memory top at reset
	localparam int MAX_TASKS     = 8;
	localparam int PTR_W         = 16;
	localparam int OP_W          = 3;
	localparam int TASK_IDX_W    = 3;
	localparam int STATUS_W      = 3;
	localparam int COUNT_W       = 4;
	localparam int TSTATE_W      = 3;
	localparam int FRAME_BYTES   = 33;
	localparam logic [PTR_W-1:0] MEMORY_TOP_RST = 16'hFFFF;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_CREATE    = 3'd0,
		OP_TERMINATE = 3'd1,
		OP_STOP      = 3'd2,
		OP_RESUME    = 3'd3,
		OP_TICK      = 3'd4
	} op_t;

	// per-task state
	typedef enum logic [TSTATE_W-1:0] {
		TS_FRESH      = 3'd0,
		TS_READY      = 3'd1,
		TS_RUNNING    = 3'd2,
		TS_STOPPED    = 3'd3,
		TS_TERMINATED = 3'd4
	} tstate_t;

	// result status
	typedef enum logic [STATUS_W-1:0] {
		RS_OK         = 3'd0,
		RS_FULL       = 3'd1,
		RS_BAD_INDEX  = 3'd2,
		RS_NO_TASKS   = 3'd3,
		RS_SCHED_FAIL = 3'd4
	} rstatus_t;

	// table read address source
	typedef enum logic [1:0] {
		RD_LAST = 2'd0,
		RD_ZERO = 2'd1,
		RD_SRCH = 2'd2,
		RD_RUN  = 2'd3
	} rd_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     create;
		logic     set_state;
		logic     pop;
		logic     srch_init;
		logic     srch_next;
		logic     take_fresh;
		logic     demote;
		logic     promote_one;
		logic     dispatch;
		logic     finish;
		rstatus_t fin_status;
		rd_sel_t  rd_sel;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		op_t     op;
		logic    full;
		logic    bad_idx;
		logic    live_zero;
		logic    live_one;
		logic    visit_last;
		logic    demote_ok;
		tstate_t rd_state;
	} dp_stat_t;

endpackage

/* rtl/rrts_ram.sv */
// Generic single-write, single-read RAM with registered read data
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/rrts_ctrl.sv */
// Sequencing state machine of the task scheduler
module rrts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               cfg_ready,
	input  rrts_pkg::dp_stat_t stat,
	output rrts_pkg::dp_cmd_t  cmd
);
	import rrts_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_EXEC     = 10'b00_0000_0010,
		S_POP_RD   = 10'b00_0000_0100,
		S_POP_CHK  = 10'b00_0000_1000,
		S_SEL      = 10'b00_0001_0000,
		S_ONE_CHK  = 10'b00_0010_0000,
		S_SRCH_RD  = 10'b00_0100_0000,
		S_SRCH_CHK = 10'b00_1000_0000,
		S_DSP_CHK  = 10'b01_0000_0000,
		S_DSP_WR   = 10'b10_0000_0000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.op)
					OP_CREATE: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (stat.full) begin
							cmd.fin_status = RS_FULL;
						end else begin
							cmd.create     = 1'b1;
							cmd.fin_status = RS_OK;
						end
					end
					OP_TERMINATE, OP_STOP, OP_RESUME: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (stat.bad_idx) begin
							cmd.fin_status = RS_BAD_INDEX;
						end else begin
							cmd.set_state  = 1'b1;
							cmd.fin_status = RS_OK;
						end
					end
					OP_TICK: begin
						state_d = S_POP_RD;
					end
					default: begin
						// undefined op: no change, plain ok
						cmd.finish     = 1'b1;
						cmd.fin_status = RS_OK;
						state_d        = S_IDLE;
					end
				endcase
			end
			S_POP_RD: begin
				if (stat.live_zero) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = RS_NO_TASKS;
					state_d        = S_IDLE;
				end else begin
					cmd.rd_sel = RD_LAST;
					state_d    = S_POP_CHK;
				end
			end
			S_POP_CHK: begin
				if (stat.rd_state == TS_TERMINATED) begin
					cmd.pop = 1'b1;
					state_d = S_POP_RD;
				end else begin
					state_d = S_SEL;
				end
			end
			S_SEL: begin
				if (stat.live_one) begin
					cmd.rd_sel = RD_ZERO;
					state_d    = S_ONE_CHK;
				end else begin
					cmd.srch_init = 1'b1;
					state_d       = S_SRCH_RD;
				end
			end
			S_ONE_CHK: begin
				cmd.promote_one = 1'b1;
				cmd.finish      = 1'b1;
				cmd.fin_status  = RS_OK;
				state_d         = S_IDLE;
			end
			S_SRCH_RD: begin
				cmd.rd_sel = RD_SRCH;
				state_d    = S_SRCH_CHK;
			end
			S_SRCH_CHK: begin
				// fetch the running task's state in case of a dispatch
				cmd.rd_sel = RD_RUN;
				case (stat.rd_state) inside
					TS_STOPPED: begin
						if (stat.visit_last) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = RS_SCHED_FAIL;
							state_d        = S_IDLE;
						end else begin
							cmd.srch_next = 1'b1;
							state_d       = S_SRCH_RD;
						end
					end
					TS_READY, TS_FRESH: begin
						cmd.take_fresh = 1'b1;
						state_d        = S_DSP_CHK;
					end
					default: begin
						cmd.finish     = 1'b1;
						cmd.fin_status = RS_SCHED_FAIL;
						state_d        = S_IDLE;
					end
				endcase
			end
			S_DSP_CHK: begin
				cmd.demote = stat.demote_ok;
				state_d    = S_DSP_WR;
			end
			S_DSP_WR: begin
				cmd.dispatch   = 1'b1;
				cmd.finish     = 1'b1;
				cmd.fin_status = RS_OK;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/rrts_dp.sv */
// Task table, pointers and result registers of the task scheduler
module rrts_dp #(
	parameter int MAX_TASKS = rrts_pkg::MAX_TASKS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rrts_pkg::dp_cmd_t               cmd,
	output rrts_pkg::dp_stat_t              stat,
	input  logic [rrts_pkg::OP_W-1:0]       op,
	input  logic [rrts_pkg::TASK_IDX_W-1:0] task_index,
	input  logic [rrts_pkg::PTR_W-1:0]      stack_size,
	input  logic                            cfg_we,
	input  logic [rrts_pkg::PTR_W-1:0]      cfg_data,
	output logic                            done,
	output logic [rrts_pkg::STATUS_W-1:0]   status,
	output logic [rrts_pkg::TASK_IDX_W-1:0] next_task,
	output logic                            fresh_start,
	output logic [rrts_pkg::PTR_W-1:0]      stack_top,
	output logic [rrts_pkg::COUNT_W-1:0]    task_count
);
	import rrts_pkg::*;

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	// compare width wide enough for every index and count
	localparam int WW    = IDX_W + 4;

	// control state
	logic [CNT_W-1:0] live_q;
	logic [IDX_W-1:0] run_q;
	logic [PTR_W-1:0] fp_q;
	logic             done_q;

	// latched word and search state
	op_t                   op_q;
	logic [TASK_IDX_W-1:0] tidx_q;
	logic [PTR_W-1:0]      size_q;
	logic [IDX_W-1:0]      srch_q;
	logic [CNT_W-1:0]      visits_q;

	// result registers
	rstatus_t              status_q;
	logic [TASK_IDX_W-1:0] next_task_q;
	logic                  fresh_q;
	logic [PTR_W-1:0]      stack_top_q;

	// table ports
	logic [IDX_W-1:0]    raddr;
	logic [IDX_W-1:0]    st_waddr;
	logic [TSTATE_W-1:0] st_wdata;
	logic                st_we;
	logic [TSTATE_W-1:0] st_rdata;
	logic [PTR_W-1:0]    base_rdata;
	tstate_t             rd_state;
	tstate_t             set_code;

	// next index round-robin, wrapping at the live count
	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] x,
	                                               input logic [CNT_W-1:0] n);
		logic [WW-1:0] nx;
		nx = WW'(x) + WW'(1);
		return (nx >= WW'(n)) ? '0 : IDX_W'(nx);
	endfunction

	assign rd_state = tstate_t'(st_rdata);

	// status towards the controller
	always_comb begin
		stat.op         = op_q;
		stat.full       = (WW'(live_q) >= WW'(MAX_TASKS));
		stat.bad_idx    = (WW'(tidx_q) >= WW'(live_q));
		stat.live_zero  = (live_q == '0);
		stat.live_one   = (live_q == CNT_W'(1));
		stat.visit_last = ((WW'(visits_q) + WW'(1)) >= WW'(live_q));
		stat.demote_ok  = (WW'(run_q) < WW'(live_q)) && (run_q != srch_q) &&
		                  (rd_state == TS_RUNNING);
		stat.rd_state   = rd_state;
	end

	// read address select
	always_comb begin
		unique case (cmd.rd_sel)
			RD_LAST: raddr = IDX_W'(WW'(live_q) - WW'(1));
			RD_ZERO: raddr = '0;
			RD_SRCH: raddr = srch_q;
			RD_RUN:  raddr = run_q;
			default: raddr = '0;
		endcase
	end

	// state written by terminate, stop and resume
	always_comb begin
		case (op_q)
			OP_TERMINATE: set_code = TS_TERMINATED;
			OP_STOP:      set_code = TS_STOPPED;
			default:      set_code = TS_READY;
		endcase
	end

	// state table write select
	always_comb begin
		st_we    = 1'b0;
		st_waddr = '0;
		st_wdata = TS_FRESH;
		if (cmd.create) begin
			st_we    = 1'b1;
			st_waddr = IDX_W'(live_q);
			st_wdata = TS_FRESH;
		end else if (cmd.set_state) begin
			st_we    = 1'b1;
			st_waddr = IDX_W'(tidx_q);
			st_wdata = set_code;
		end else if (cmd.demote) begin
			st_we    = 1'b1;
			st_waddr = run_q;
			st_wdata = TS_READY;
		end else if (cmd.promote_one) begin
			// lone task: fresh or ready runs, stopped stays stopped
			st_we    = (rd_state == TS_FRESH) || (rd_state == TS_READY);
			st_waddr = '0;
			st_wdata = TS_RUNNING;
		end else if (cmd.dispatch) begin
			st_we    = 1'b1;
			st_waddr = srch_q;
			st_wdata = TS_RUNNING;
		end
	end

	rrts_ram #(
		.WIDTH (TSTATE_W),
		.DEPTH (MAX_TASKS)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (raddr),
		.rdata (st_rdata)
	);

	rrts_ram #(
		.WIDTH (PTR_W),
		.DEPTH (MAX_TASKS)
	) u_base_ram (
		.clk   (clk),
		.we    (cmd.create),
		.waddr (IDX_W'(live_q)),
		.wdata (fp_q),
		.raddr (raddr),
		.rdata (base_rdata)
	);

	// live count, running task, free pointer, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			run_q  <= '0;
			fp_q   <= MEMORY_TOP_RST;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.create) begin
				fp_q   <= fp_q - size_q - PTR_W'(FRAME_BYTES);
				live_q <= live_q + CNT_W'(1);
			end else if (cmd.pop) begin
				fp_q   <= base_rdata;
				live_q <= live_q - CNT_W'(1);
			end else if (cfg_we && (live_q == '0)) begin
				// memory top only matters while the table is empty
				fp_q <= cfg_data;
			end
			if (cmd.promote_one) begin
				run_q <= '0;
			end else if (cmd.dispatch) begin
				run_q <= srch_q;
			end
		end
	end

	// latched word, search index and results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= op_t'(op);
			tidx_q      <= task_index;
			size_q      <= stack_size;
			next_task_q <= '0;
			fresh_q     <= 1'b0;
			stack_top_q <= '0;
		end
		if (cmd.create) begin
			stack_top_q <= fp_q;
		end
		if (cmd.srch_init) begin
			srch_q   <= wrap_next(run_q, live_q);
			visits_q <= '0;
		end else if (cmd.srch_next) begin
			srch_q   <= wrap_next(srch_q, live_q);
			visits_q <= visits_q + CNT_W'(1);
		end
		if (cmd.take_fresh || cmd.promote_one) begin
			fresh_q <= (rd_state == TS_FRESH);
		end
		if (cmd.dispatch) begin
			next_task_q <= TASK_IDX_W'(srch_q);
		end
		if (cmd.finish) begin
			status_q <= cmd.fin_status;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign next_task   = next_task_q;
	assign fresh_start = fresh_q;
	assign stack_top   = stack_top_q;
	assign task_count  = COUNT_W'(live_q);

endmodule

/* rtl/round_robin_task_scheduler.sv */
// Round-robin task scheduler top level: controller and datapath
//
//  channel   handshake              word
//  command   start / busy           op, task_index, stack_size
//  result    done (strobe)          status, next_task, fresh_start, stack_top, task_count
//  config    cfg_valid / cfg_ready  cfg_data (memory top)
//
// create, terminate, stop, resume and undefined ops: accept, execute, then done registered.
// tick: pop terminated tasks off the end, then promote a lone task or search for a ready
// or fresh one to dispatch, paced by the single read port of the task table.
// busy drops in the done cycle, so a new command can be taken alongside the result.
// done is a one-cycle strobe; results are not held back. Config is taken only when idle.
// Reset: empty table, running task 0, free pointer at 16'hFFFF.
module round_robin_task_scheduler #(
	parameter int MAX_TASKS = rrts_pkg::MAX_TASKS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [rrts_pkg::OP_W-1:0]       op,
	input  logic [rrts_pkg::TASK_IDX_W-1:0] task_index,
	input  logic [rrts_pkg::PTR_W-1:0]      stack_size,
	output logic                            done,
	output logic [rrts_pkg::STATUS_W-1:0]   status,
	output logic [rrts_pkg::TASK_IDX_W-1:0] next_task,
	output logic                            fresh_start,
	output logic [rrts_pkg::PTR_W-1:0]      stack_top,
	output logic [rrts_pkg::COUNT_W-1:0]    task_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rrts_pkg::PTR_W-1:0]      cfg_data
);
	import rrts_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rrts_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.task_index  (task_index),
		.stack_size  (stack_size),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.next_task   (next_task),
		.fresh_start (fresh_start),
		.stack_top   (stack_top),
		.task_count  (task_count)
	);

endmodule

/* rtl/rrts_checker.sv */
// Port-level checks of the task scheduler and their bind
`include "round_robin_task_scheduler_macros.svh"

module rrts_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [rrts_pkg::STATUS_W-1:0]   status,
	input logic [rrts_pkg::TASK_IDX_W-1:0] next_task,
	input logic                            fresh_start,
	input logic [rrts_pkg::PTR_W-1:0]      stack_top
);
	import rrts_pkg::*;

	// an accepted command always makes the block busy in the following cycle
	`RRTS_ASSERT_NXT(a_accept_busy, start && !busy, busy)

	// every result comes out of a busy cycle
	`RRTS_ASSERT_IMP(a_done_after_busy, done, $past(busy))

	// results never come back to back
	`RRTS_ASSERT_NXT(a_done_single, done, !done)

	// a failed step hands out no task and no stack
	`RRTS_ASSERT_IMP(a_fail_clean, done && (status != RS_OK), (next_task == '0) && !fresh_start && (stack_top == '0))

endmodule

bind round_robin_task_scheduler rrts_port_checks u_rrts_port_checks (.*);
